// File: hdl/packet_loss_jitter_monitor_assert.svh
// ----------------------------------------------------------------------------
// packet_loss_jitter_monitor_assert.svh
// Assertion macros shared by the monitor modules, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef PACKET_LOSS_JITTER_MONITOR_ASSERT_SVH
`define PACKET_LOSS_JITTER_MONITOR_ASSERT_SVH

// property must hold at every clock edge out of reset
`define PLJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PLJ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/plj_pkg.sv
// ----------------------------------------------------------------------------
// plj_pkg
// Widths, constants and handshake structs of the packet loss and jitter
// monitor
// ----------------------------------------------------------------------------
package plj_pkg;

  // item fields
  localparam int ARR_W      = 40;
  localparam int SEQ_W      = 27;
  localparam int SIZE_W     = 16;
  localparam int RCV_OUT_W  = 40;
  localparam int LOSS_W     = 32;
  localparam int RATE_W     = 32;
  localparam int JIT_W      = 40;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 176;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1000;
  localparam logic [9:0]        MS_PER_S   = 10'd1000;
  localparam logic [SEQ_W-1:0]  SEQ_MAX    = {SEQ_W{1'b1}};
  localparam int                DSUM_W     = 48;

  // shared divider
  localparam int DIV_NUM_W    = 82;
  localparam int DIV_DEN_W    = 48;
  localparam int DIV_Q_W      = 40;
  localparam int DIV_NARROW_W = 32;
  localparam int DIV_CNT_W    = 6;

  // rate numerator pieces
  localparam int MUL_A_W   = 26;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = 50;
  localparam int MUL_ACC_W = 74;

  typedef struct packed {
    logic start;
    logic wide;   // 40 quotient bits, else 32
  } div_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_rsp_t;

  typedef struct packed {
    logic take;
    logic dev_en;
    logic sum_en;
  } stats_ctl_t;

endpackage

// File: hdl/packet_loss_jitter_monitor.sv
// An accepted beat runs through S_DEV, S_MUL0, S_MUL1, S_ADD, the loss, rate
// and jitter divisions (32, 32 and 40 quotient bits on the shared divider)
// and S_OUT; the rate division is skipped when the arrival time is zero, and
// a quotient that overflows ends with no divider steps. s_axis_tready is low
// while an item is at work: no new item until the output register is loaded.
// Reset clears the running statistics, sets the packet size to 1000 bytes.
// ----------------------------------------------------------------------------
// packet_loss_jitter_monitor
// Receive-side loss, throughput and jitter statistics for numbered packets,
// three saturating quotients from one sequenced divider
// ----------------------------------------------------------------------------
`include "packet_loss_jitter_monitor_assert.svh"

module packet_loss_jitter_monitor #(
  parameter int TIME_BITS  = 40,
  parameter int COUNT_BITS = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [plj_pkg::SIZE_W-1:0]         cfg_data_i,   // packet_size_bytes
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // arrival_time_us, sequence_number, zero pad
  input  logic [plj_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // received_count, lost_count, loss_ratio, rate, jitter_us, zero pad
  output logic [plj_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [0:0]                         m_axis_tuser  // rate_saturated
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'h001,
    S_DEV       = 12'h002,
    S_MUL0      = 12'h004,
    S_MUL1      = 12'h008,
    S_ADD       = 12'h010,
    S_LOSS_GO   = 12'h020,
    S_LOSS_WAIT = 12'h040,
    S_RATE_GO   = 12'h080,
    S_RATE_WAIT = 12'h100,
    S_JIT_GO    = 12'h200,
    S_JIT_WAIT  = 12'h400,
    S_OUT       = 12'h800
  } state_e;

  state_e                                state_q, state_d;
  logic [plj_pkg::SIZE_W-1:0]            size_q;
  logic [plj_pkg::MUL_A_W-1:0]           a_q;
  logic [plj_pkg::MUL_P_W-1:0]           pp_q;
  logic [plj_pkg::MUL_ACC_W-1:0]         acc_q;
  logic [plj_pkg::LOSS_W-1:0]            loss_q;
  logic [plj_pkg::RATE_W-1:0]            rate_q;
  logic                                  rsat_q;
  logic [plj_pkg::JIT_W-1:0]             jit_q;
  logic                                  m_valid_q;
  logic [plj_pkg::OUT_DATA_W-1:0]        m_data_q;
  logic                                  m_sat_q;

  logic                                  accept_w;
  logic                                  out_load_w;
  plj_pkg::stats_ctl_t                   st_ctl;
  logic [COUNT_BITS-1:0]                 rcv_w;
  logic [plj_pkg::SEQ_W-1:0]             lost_w;
  logic [plj_pkg::DSUM_W-1:0]            dsum_w;
  logic [TIME_BITS-1:0]                  time_w;
  logic [plj_pkg::DIV_DEN_W-1:0]         rcv48_w;
  logic [plj_pkg::DIV_DEN_W-1:0]         t48_w;
  logic                                  t_zero_w;
  logic [plj_pkg::MUL_B_W-1:0]           mul_b_w;
  logic [plj_pkg::MUL_P_W-1:0]           prod_w;
  plj_pkg::div_req_t                     div_req;
  plj_pkg::div_rsp_t                     div_rsp;
  logic [plj_pkg::DIV_NUM_W-1:0]         div_num;
  logic [plj_pkg::DIV_DEN_W-1:0]         div_den;
  logic [plj_pkg::DIV_Q_W-1:0]           div_quo;
  logic [plj_pkg::RCV_OUT_W-1:0]         rcv_out_w;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept_w      = s_axis_tvalid && s_axis_tready;
  assign out_load_w    = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  assign st_ctl.take   = accept_w;
  assign st_ctl.dev_en = (state_q == S_DEV);
  assign st_ctl.sum_en = (state_q == S_MUL0);

  plj_stats #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .arrival_i (s_axis_tdata[plj_pkg::ARR_W-1:0]),
    .seq_i     (s_axis_tdata[plj_pkg::ARR_W +: plj_pkg::SEQ_W]),
    .rcv_o     (rcv_w),
    .lost_o    (lost_w),
    .dsum_o    (dsum_w),
    .time_o    (time_w)
  );

  assign rcv48_w  = plj_pkg::DIV_DEN_W'(rcv_w);
  assign t48_w    = plj_pkg::DIV_DEN_W'(time_w);
  assign t_zero_w = (t48_w == '0);

  // size * 1000 * received, as two 24-bit slices of the count
  assign mul_b_w = (state_q == S_MUL0) ? rcv48_w[plj_pkg::MUL_B_W-1:0]
                                       : rcv48_w[plj_pkg::DIV_DEN_W-1:plj_pkg::MUL_B_W];
  assign prod_w  = plj_pkg::MUL_P_W'(a_q) * plj_pkg::MUL_P_W'(mul_b_w);

  always_comb begin
    div_req.start = 1'b0;
    div_req.wide  = 1'b0;
    div_num       = '0;
    div_den       = rcv48_w;
    case (state_q)
      S_LOSS_GO: begin
        div_req.start = 1'b1;
        div_num       = plj_pkg::DIV_NUM_W'({lost_w, 16'h0000});
      end
      S_RATE_GO: begin
        div_req.start = !t_zero_w;
        div_num       = {acc_q, 8'h00};
        div_den       = t48_w;
      end
      // the divider reads its divisor on every step
      S_RATE_WAIT: begin
        div_den       = t48_w;
      end
      S_JIT_GO: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b1;
        div_num       = plj_pkg::DIV_NUM_W'({dsum_w, 8'h00});
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  plj_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .rsp_o  (div_rsp),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (accept_w) state_d = S_DEV;
      S_DEV:       state_d = S_MUL0;
      S_MUL0:      state_d = S_MUL1;
      S_MUL1:      state_d = S_ADD;
      S_ADD:       state_d = S_LOSS_GO;
      S_LOSS_GO:   state_d = S_LOSS_WAIT;
      S_LOSS_WAIT: if (div_rsp.done) state_d = S_RATE_GO;
      S_RATE_GO:   state_d = t_zero_w ? S_JIT_GO : S_RATE_WAIT;
      S_RATE_WAIT: if (div_rsp.done) state_d = S_JIT_GO;
      S_JIT_GO:    state_d = S_JIT_WAIT;
      S_JIT_WAIT:  if (div_rsp.done) state_d = S_OUT;
      S_OUT:       if (out_load_w) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      size_q    <= plj_pkg::SIZE_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
      if (out_load_w) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // received count clamps to the output field
  assign rcv_out_w = (rcv48_w[plj_pkg::DIV_DEN_W-1:plj_pkg::RCV_OUT_W] != '0)
                     ? {plj_pkg::RCV_OUT_W{1'b1}} : rcv48_w[plj_pkg::RCV_OUT_W-1:0];

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DEV:  a_q <= plj_pkg::MUL_A_W'(size_q) * plj_pkg::MUL_A_W'(plj_pkg::MS_PER_S);
      S_MUL0: pp_q <= prod_w;
      S_MUL1: begin
        acc_q <= plj_pkg::MUL_ACC_W'(pp_q);
        pp_q  <= prod_w;
      end
      S_ADD:  acc_q <= acc_q + {pp_q, plj_pkg::MUL_B_W'(0)};
      S_LOSS_WAIT: if (div_rsp.done) loss_q <= div_quo[plj_pkg::LOSS_W-1:0];
      S_RATE_GO: begin
        // zero elapsed time: rate pinned at all ones
        rate_q <= {plj_pkg::RATE_W{1'b1}};
        rsat_q <= 1'b1;
      end
      S_RATE_WAIT: begin
        if (div_rsp.done) begin
          rate_q <= div_quo[plj_pkg::RATE_W-1:0];
          rsat_q <= div_rsp.sat;
        end
      end
      S_JIT_WAIT: if (div_rsp.done) jit_q <= div_quo;
      default: ;
    endcase
    if (out_load_w) begin
      m_data_q <= plj_pkg::OUT_DATA_W'({jit_q, rate_q, loss_q, lost_w, rcv_out_w});
      m_sat_q  <= rsat_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_sat_q;

  `PLJ_ASSERT(a_accept_seq, accept_w |=> (state_q == S_DEV), "accepted beat did not start work")
  `PLJ_ASSERT(a_done_wait, div_rsp.done |-> (state_q == S_LOSS_WAIT || state_q == S_RATE_WAIT || state_q == S_JIT_WAIT), "divider result outside a wait state")
  `PLJ_ASSERT(a_sat_rate, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[130:99] == 32'hFFFF_FFFF), "saturated rate not all ones")

endmodule

// File: hdl/plj_divider.sv
// ----------------------------------------------------------------------------
// plj_divider
// Shared restoring divider, one quotient bit per cycle, quotient saturating
// at 32 or 40 ones
// ----------------------------------------------------------------------------
`include "packet_loss_jitter_monitor_assert.svh"

module plj_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  plj_pkg::div_req_t                req_i,
  input  logic [plj_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [plj_pkg::DIV_DEN_W-1:0]    den_i,
  output plj_pkg::div_rsp_t                rsp_o,
  output logic [plj_pkg::DIV_Q_W-1:0]      quo_o
);

  logic                            busy_q;
  logic                            done_q;
  logic                            sat_q;
  logic [plj_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [plj_pkg::DIV_DEN_W-1:0]   rem_q;
  logic [plj_pkg::DIV_Q_W-1:0]     low_q;
  logic [plj_pkg::DIV_Q_W-1:0]     quo_q;

  logic [plj_pkg::DIV_DEN_W+1:0]   init_w;
  logic                            over_w;
  logic [plj_pkg::DIV_DEN_W:0]     trial_w;
  logic [plj_pkg::DIV_DEN_W:0]     diff_w;
  logic                            fits_w;

  // quotient overflows when the part above the quotient bits reaches the divisor
  assign init_w = req_i.wide ? (plj_pkg::DIV_DEN_W+2)'(num_i[plj_pkg::DIV_NUM_W-1:plj_pkg::DIV_Q_W])
                             : num_i[plj_pkg::DIV_NUM_W-1:plj_pkg::DIV_NARROW_W];
  assign over_w = init_w >= (plj_pkg::DIV_DEN_W+2)'(den_i);

  assign trial_w = {rem_q, low_q[plj_pkg::DIV_Q_W-1]};
  assign fits_w  = trial_w >= (plj_pkg::DIV_DEN_W+1)'(den_i);
  assign diff_w  = trial_w - (plj_pkg::DIV_DEN_W+1)'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= !over_w;
      done_q <= over_w;
      sat_q  <= over_w;
      cnt_q  <= req_i.wide ? plj_pkg::DIV_CNT_W'(plj_pkg::DIV_Q_W)
                           : plj_pkg::DIV_CNT_W'(plj_pkg::DIV_NARROW_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == plj_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= init_w[plj_pkg::DIV_DEN_W-1:0];
      low_q <= req_i.wide ? num_i[plj_pkg::DIV_Q_W-1:0]
                          : {num_i[plj_pkg::DIV_NARROW_W-1:0],
                             (plj_pkg::DIV_Q_W-plj_pkg::DIV_NARROW_W)'(0)};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits_w ? diff_w[plj_pkg::DIV_DEN_W-1:0] : trial_w[plj_pkg::DIV_DEN_W-1:0];
      low_q <= {low_q[plj_pkg::DIV_Q_W-2:0], 1'b0};
      quo_q <= {quo_q[plj_pkg::DIV_Q_W-2:0], fits_w};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign quo_o      = sat_q ? {plj_pkg::DIV_Q_W{1'b1}} : quo_q;

  `PLJ_NEVER(a_start_busy, req_i.start && busy_q, "divider started while busy")
  `PLJ_ASSERT(a_done_src, rsp_o.done |-> $past(busy_q || req_i.start), "done without work")
  `PLJ_NEVER(a_busy_cnt, busy_q && (cnt_q == '0), "divider busy with no steps left")

endmodule

// File: hdl/plj_stats.sv
// ----------------------------------------------------------------------------
// plj_stats
// Running packet statistics: counts, highest sequence, gaps and the
// saturating sum of gap changes
// ----------------------------------------------------------------------------
module plj_stats #(
  parameter int TIME_BITS  = 40,
  parameter int COUNT_BITS = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plj_pkg::stats_ctl_t            ctl_i,
  input  logic [plj_pkg::ARR_W-1:0]      arrival_i,
  input  logic [plj_pkg::SEQ_W-1:0]      seq_i,
  output logic [COUNT_BITS-1:0]          rcv_o,
  output logic [plj_pkg::SEQ_W-1:0]      lost_o,
  output logic [plj_pkg::DSUM_W-1:0]     dsum_o,
  output logic [TIME_BITS-1:0]           time_o
);

  localparam int TIN   = (TIME_BITS < plj_pkg::ARR_W) ? TIME_BITS : plj_pkg::ARR_W;
  localparam int CMP_W = ((COUNT_BITS > plj_pkg::SEQ_W + 1) ? COUNT_BITS
                                                            : plj_pkg::SEQ_W + 1) + 1;

  logic [COUNT_BITS-1:0]        rcv_q;
  logic [plj_pkg::SEQ_W-1:0]    high_q;
  logic [TIME_BITS-1:0]         last_t_q;
  logic [TIME_BITS-1:0]         last_gap_q;
  logic [plj_pkg::DSUM_W-1:0]   dsum_q;
  logic [TIME_BITS-1:0]         gap_q;
  logic [TIME_BITS-1:0]         dev_q;
  logic                         first_q;
  logic [plj_pkg::SEQ_W-1:0]    lost_q;

  logic [TIME_BITS-1:0]         t_w;
  logic [CMP_W-1:0]             hp1_w;
  logic [CMP_W-1:0]             rcv_w;
  logic [CMP_W-1:0]             lost_w;
  logic [plj_pkg::DSUM_W:0]     sum_w;

  assign t_w    = TIME_BITS'(arrival_i[TIN-1:0]);
  assign hp1_w  = CMP_W'(high_q) + CMP_W'(1);
  assign rcv_w  = CMP_W'(rcv_q);
  assign lost_w = hp1_w - rcv_w;
  assign sum_w  = {1'b0, dsum_q} + (plj_pkg::DSUM_W+1)'(dev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q      <= '0;
      high_q     <= '0;
      last_t_q   <= '0;
      last_gap_q <= '0;
      dsum_q     <= '0;
    end else begin
      if (ctl_i.take) begin
        if (seq_i > high_q) begin
          high_q <= seq_i;
        end
        if (rcv_q != {COUNT_BITS{1'b1}}) begin
          rcv_q <= rcv_q + 1'b1;
        end
        last_t_q <= t_w;
      end
      if (ctl_i.dev_en) begin
        last_gap_q <= gap_q;
      end
      // the first packet gives no gap change
      if (ctl_i.sum_en && !first_q) begin
        dsum_q <= sum_w[plj_pkg::DSUM_W] ? {plj_pkg::DSUM_W{1'b1}}
                                         : sum_w[plj_pkg::DSUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      gap_q   <= t_w - last_t_q;
      first_q <= (rcv_q == '0);
    end
    if (ctl_i.dev_en) begin
      dev_q <= (gap_q >= last_gap_q) ? gap_q - last_gap_q : last_gap_q - gap_q;
      if (hp1_w > rcv_w) begin
        lost_q <= (lost_w > CMP_W'(plj_pkg::SEQ_MAX)) ? plj_pkg::SEQ_MAX
                                                      : lost_w[plj_pkg::SEQ_W-1:0];
      end else begin
        lost_q <= '0;
      end
    end
  end

  assign rcv_o  = rcv_q;
  assign lost_o = lost_q;
  assign dsum_o = dsum_q;
  assign time_o = last_t_q;

endmodule
